// ===== hw/rtl/chunked_transfer_receive_tracker_unit_assert.svh =====
// Assertion macros shared by the receive tracker RTL.
// Plain header, no dependencies; pulled in by `include where assertions are written.
`ifndef CHUNKED_TRANSFER_RECEIVE_TRACKER_UNIT_ASSERT_SVH
`define CHUNKED_TRANSFER_RECEIVE_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define CTRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define CTRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ctrt_pkg.sv =====
// Types and constants for the chunked transfer receive tracker.
// No dependencies; imported by ctrt_update and the top level.
package ctrt_pkg;

    localparam logic [15:0] TIMEOUT_RST = 16'd5;
    localparam logic [16:0] IDLE_MAX    = 17'h1FFFF;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SEND      = 3'd1,
        OP_RECV_NOTE = 3'd2,
        OP_ACK_NOTE  = 3'd3,
        OP_CHUNK     = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_NONE     = 4'd0,
        ST_SEND_OK  = 4'd1,
        ST_DEFERRED = 4'd2,
        ST_STORED   = 4'd3,
        ST_IGNORED  = 4'd4,
        ST_COMPLETE = 4'd5,
        ST_OVERRUN  = 4'd6,
        ST_TIMEOUT  = 4'd7,
        ST_NOTICE   = 4'd8
    } status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  source_node;
        logic [30:0] byte_total;
        logic [21:0] chunk_index;
        logic [15:0] chunk_length;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  ack_node;
        logic        write_valid;
        logic [31:0] write_offset;
        logic [15:0] write_length;
        logic        receiving;
    } result_t;

    // chunk_bytes holds received chunks times the chunk size, so the chunk
    // count checks become byte compares against the announced size.
    typedef struct packed {
        logic        busy;
        logic [7:0]  peer_node;
        logic [30:0] expected_bytes;
        logic [31:0] chunk_bytes;
        logic [31:0] received_bytes;
        logic [16:0] idle_count;
    } track_t;

endpackage

// ===== hw/rtl/ctrt_update.sv =====
// Per-request update of the transfer tracking state and the result fields.
// Depends on ctrt_pkg.
module ctrt_update #(
    parameter int CHUNK_BYTES = 1024
) (
    input  ctrt_pkg::item_t   item,
    input  ctrt_pkg::track_t  trk,
    input  logic [15:0]       timeout_ticks,
    output ctrt_pkg::track_t  trk_next,
    output ctrt_pkg::result_t res
);
    import ctrt_pkg::*;

    localparam logic [31:0] CHUNK_STEP = 32'(CHUNK_BYTES);

    logic [16:0] idle_inc;
    logic [32:0] byte_sum;
    logic [31:0] bytes_new;
    logic [31:0] cbytes_new;
    logic [31:0] size_ext;
    logic        bytes_eq;
    logic        bytes_ge;
    logic        chunks_ge;
    logic        chunks_eq;
    logic        from_peer;

    always_comb begin
        idle_inc   = (trk.idle_count < IDLE_MAX) ? trk.idle_count + 17'd1 : trk.idle_count;
        byte_sum   = {1'b0, trk.received_bytes} + {17'd0, item.chunk_length};
        bytes_new  = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
        cbytes_new = trk.chunk_bytes + CHUNK_STEP;
        size_ext   = {1'b0, trk.expected_bytes};
        bytes_eq   = (bytes_new == size_ext);
        bytes_ge   = (bytes_new >= size_ext);
        // chunks >= ceil(size/CB)  <=>  chunks*CB >= size
        chunks_ge  = (cbytes_new >= size_ext);
        chunks_eq  = chunks_ge && (cbytes_new < size_ext + CHUNK_STEP);
        from_peer  = trk.busy && (item.source_node == trk.peer_node);
    end

    always_comb begin
        trk_next = trk;
        res      = '0;
        res.status = ST_NONE;
        unique case (opcode_t'(item.opcode))
            OP_TICK: begin
                if (trk.busy) begin
                    trk_next.idle_count = idle_inc;
                    if (idle_inc > {1'b0, timeout_ticks}) begin
                        trk_next.busy = 1'b0;
                        res.status    = ST_TIMEOUT;
                    end
                end
            end
            OP_SEND: begin
                if (trk.busy) begin
                    res.status = ST_DEFERRED;
                end else begin
                    trk_next.busy           = 1'b1;
                    trk_next.peer_node      = item.source_node;
                    trk_next.expected_bytes = item.byte_total;
                    trk_next.chunk_bytes    = '0;
                    trk_next.received_bytes = '0;
                    trk_next.idle_count     = '0;
                    res.status              = ST_SEND_OK;
                    res.ack_node            = item.source_node;
                end
            end
            OP_RECV_NOTE, OP_ACK_NOTE: begin
                res.status = ST_NOTICE;
            end
            OP_CHUNK: begin
                if (from_peer) begin
                    res.write_valid         = 1'b1;
                    res.write_offset        = {10'd0, item.chunk_index} * CHUNK_STEP;
                    res.write_length        = item.chunk_length;
                    trk_next.idle_count     = '0;
                    trk_next.received_bytes = bytes_new;
                    trk_next.chunk_bytes    = cbytes_new;
                    if (bytes_eq && chunks_eq) begin
                        trk_next.busy = 1'b0;
                        res.status    = ST_COMPLETE;
                    end else if (bytes_ge || chunks_ge) begin
                        trk_next.busy = 1'b0;
                        res.status    = ST_OVERRUN;
                    end else begin
                        res.status = ST_STORED;
                    end
                end else begin
                    res.status = ST_IGNORED;
                end
            end
            default: begin
                res.status = ST_NONE;
            end
        endcase
        res.receiving = trk_next.busy;
    end

endmodule

// ===== hw/rtl/chunked_transfer_receive_tracker_unit.sv =====
// Channel   Dir  Contents
// s_*       in   decoded packet header or tick; tuser = opcode
// m_*       out  one result per request; tuser = status
// cfg_*     in   timeout_ticks register write
//
// Two-stage pipeline: input register, then tracker update into the result
// register. One request per cycle while the result is not stalled.
// The tracker state updates when a request moves into the result register.
// A stalled result holds both stages; s_tready stays high while the input
// register is empty. Reset (aresetn low, synchronous) returns to idle and
// sets timeout_ticks to 5.
// Depends on ctrt_pkg, ctrt_update and the assertion macro header.
`include "chunked_transfer_receive_tracker_unit_assert.svh"

module chunked_transfer_receive_tracker_unit #(
    parameter int CHUNK_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // timeout_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // source_node[7:0], byte_total[38:8], chunk_index[60:39],
                                  // chunk_length[76:61], zero pad
    input  logic [2:0]  s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // ack_node[7:0], write_valid[8], write_offset[40:9],
                                  // write_length[56:41], receiving[57], zero pad
    output logic [3:0]  m_tuser   // status
);
    import ctrt_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    track_t      trk_reg;
    track_t      trk_next;
    result_t     res_next;
    logic [15:0] timeout_reg;
    logic        advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    ctrt_update #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_update (
        .item         (in_item_reg),
        .trk          (trk_reg),
        .timeout_ticks(timeout_reg),
        .trk_next     (trk_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            trk_reg       <= '0;
            timeout_reg   <= TIMEOUT_RST;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    trk_reg <= trk_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.opcode       <= s_tuser;
            in_item_reg.source_node  <= s_tdata[7:0];
            in_item_reg.byte_total   <= s_tdata[38:8];
            in_item_reg.chunk_index  <= s_tdata[60:39];
            in_item_reg.chunk_length <= s_tdata[76:61];
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {6'd0,
                       out_res_reg.receiving,
                       out_res_reg.write_length,
                       out_res_reg.write_offset,
                       out_res_reg.write_valid,
                       out_res_reg.ack_node};

    // a write goes out only with a stored, complete or overrun status
    `CTRT_ASSERT_IMP(a_write_status, aclk, aresetn, out_valid_reg && out_res_reg.write_valid, out_res_reg.status == ST_STORED || out_res_reg.status == ST_COMPLETE || out_res_reg.status == ST_OVERRUN)
    // the receiving flag of a pending result matches the live tracker state
    `CTRT_ASSERT_IMP(a_recv_matches, aclk, aresetn, out_valid_reg, out_res_reg.receiving == trk_reg.busy)
    // a transfer only ends through complete, overrun or timeout
    `CTRT_ASSERT_IMP(a_busy_end, aclk, aresetn, $fell(trk_reg.busy) && $past(aresetn), out_res_reg.status == ST_COMPLETE || out_res_reg.status == ST_OVERRUN || out_res_reg.status == ST_TIMEOUT)
    // an accepted send always leaves the block receiving
    `CTRT_ASSERT_NXT(a_send_busy, aclk, aresetn, advance && in_valid_reg && res_next.status == ST_SEND_OK, trk_reg.busy)

endmodule
